// File: hw/rtl/rshist_pkg.sv
package rshist_pkg;

  // Histogram geometry.
  localparam int NUM_BINS = 20;
  localparam int BIN_W = 5;
  localparam logic [BIN_W-1:0] MAX_BIN = 5'd19;

  // Allele balance bin is floor((20e-1)/n) for e > 0 and 0 for e = 0; for e > 0 the quotient never exceeds 19.
  localparam logic [4:0] BAL_SCALE = 5'd20;
  localparam int QUOT_W = 5;
  localparam int DIVIDEND_W = 21;

  // Depth bin is n/5 capped at 19. Below 95, n/5 = (n*205) >> 10 exactly.
  localparam logic [15:0] DEP_SAT = 16'd95;
  localparam logic [14:0] DEP_RECIP = 15'd205;
  localparam int DEP_RECIP_SHIFT = 10;

  // Request codes.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] sample_id;
    logic [15:0] alt_count;
    logic [15:0] depth;
    logic [19:0] quality;
    logic [30:0] draw_accept;
    logic [30:0] draw_slot;
    logic [4:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        stored;
    logic [3:0]  slot_written;
    logic [31:0] sample_count;
    logic [19:0] max_quality;
    logic [31:0] balance_count;
    logic [31:0] depth_count;
    logic [15:0] kept_id;
    logic        kept_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_MUL0,
    S_MUL1,
    S_CMP,
    S_UPD,
    S_RD,
    S_RDW,
    S_RES
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic div_start;
    logic mul_lo;
    logic mul_hi;
    logic hist_rd_add;
    logic rd_read;
    logic commit;
    logic res_zero;
    logic res_read;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic zero_depth;
    logic div_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/rshist_div.sv
module rshist_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rshist_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [15:0]                         divisor,
  output logic                                done,
  output logic [rshist_pkg::QUOT_W-1:0]       quot
);

  localparam int STEPS = rshist_pkg::QUOT_W;
  localparam int DW = rshist_pkg::DIVIDEND_W;

  logic          busy_r, busy_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [STEPS-1:0] quot_r, quot_nxt;
  logic          ge;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    ge = (rem_r >= dsr_r);
    done = busy_r && (cnt_r == 3'(STEPS - 1));
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = dividend;
      dsr_nxt = DW'(divisor) << (STEPS - 1);
      quot_nxt = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      quot_nxt = {quot_r[STEPS-2:0], ge};
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r + 3'd1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

// File: hw/rtl/rshist_dp.sv
module rshist_dp #(
  parameter int KEEP_SLOTS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rshist_pkg::dp_cmd_t   cmd,
  output rshist_pkg::dp_stat_t  stat,
  input  rshist_pkg::in_item_t  in_data,
  output rshist_pkg::out_item_t out_data
);

  localparam int SLOT_W = (KEEP_SLOTS > 1) ? $clog2(KEEP_SLOTS) : 1;
  localparam int IDX_W = (SLOT_W > 5) ? SLOT_W : 5;
  localparam int SP_W = 39;
  localparam int BIN_W = rshist_pkg::BIN_W;
  localparam int NUM_BINS = rshist_pkg::NUM_BINS;
  localparam logic [64:0] ACC_LIMIT = 65'(KEEP_SLOTS) << 32;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == '1) ? x : x + 32'd1;
  endfunction

  rshist_pkg::in_item_t  item_r;
  rshist_pkg::out_item_t res_r;
  rshist_pkg::out_item_t out_r;

  logic [31:0] count_r;
  logic [19:0] best_r;
  logic [47:0] pp_lo_r;
  logic [48:0] pp_hi_r;
  logic [SLOT_W-1:0] slot_prod_r;
  logic        keep_r;

  logic [31:0] bal_mem [NUM_BINS];
  logic [31:0] dep_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bal_vld_r;
  logic [NUM_BINS-1:0] dep_vld_r;
  logic [31:0] bal_rd_r, dep_rd_r;
  logic        bal_rv_r, dep_rv_r;
  logic [BIN_W-1:0] bal_wa_r, dep_wa_r;
  logic        bin_ok_r;

  logic [15:0] slot_mem [KEEP_SLOTS];
  logic [15:0] kid_rd_r;
  logic        kval_r;

  logic [15:0] e_cl;
  logic [rshist_pkg::DIVIDEND_W-1:0] dividend;
  logic        div_done;
  logic [rshist_pkg::QUOT_W-1:0] quot;
  logic [BIN_W-1:0] abin, dbin, rd_bin, bal_ra, dep_ra;
  logic [14:0] dq;
  logic [31:0] acc_a;
  logic [32:0] cnt_p1;
  logic [SP_W-1:0] slot_prod;
  logic [64:0] lhs;
  logic        fill, stored;
  logic [SLOT_W-1:0] slot_w, slot_ra;
  logic [IDX_W-1:0] idx_wide;
  logic [SLOT_W+3:0] slot_out;
  logic        slot_in_range;
  logic [31:0] bal_cur, dep_cur, count_new;
  logic [19:0] best_new;

  // Clamped evidence and the two bin numbers.
  always_comb begin
    e_cl = (item_r.alt_count > item_r.depth) ? item_r.depth : item_r.alt_count;
    dividend = rshist_pkg::DIVIDEND_W'(e_cl) * rshist_pkg::DIVIDEND_W'(rshist_pkg::BAL_SCALE)
               - rshist_pkg::DIVIDEND_W'(1);
    if (e_cl == 16'd0) begin
      abin = '0;
    end else if (quot > rshist_pkg::MAX_BIN) begin
      abin = rshist_pkg::MAX_BIN;
    end else begin
      abin = quot;
    end
    dq = 15'(item_r.depth[6:0]) * rshist_pkg::DEP_RECIP;
    if (item_r.depth >= rshist_pkg::DEP_SAT) begin
      dbin = rshist_pkg::MAX_BIN;
    end else begin
      dbin = dq[rshist_pkg::DEP_RECIP_SHIFT +: BIN_W];
    end
  end

  rshist_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (item_r.depth),
    .done     (div_done),
    .quot     (quot)
  );

  // Operands of the keep test (2r+1)*(count+1) < KEEP_SLOTS*2^32 and the slot draw.
  always_comb begin
    acc_a = {item_r.draw_accept, 1'b1};
    cnt_p1 = 33'(count_r) + 33'd1;
    slot_prod = SP_W'({item_r.draw_slot, 1'b1}) * SP_W'(KEEP_SLOTS);
    lhs = {pp_hi_r, 16'h0000} + 65'(pp_lo_r);
  end

  // Read addresses: the add path reads its bins, the read path reads read_index.
  always_comb begin
    rd_bin = (32'(item_r.read_index) < 32'(NUM_BINS)) ? item_r.read_index : '0;
    bal_ra = cmd.hist_rd_add ? abin : rd_bin;
    dep_ra = cmd.hist_rd_add ? dbin : rd_bin;
    idx_wide = IDX_W'(item_r.read_index);
    slot_in_range = (7'(item_r.read_index) < 7'(KEEP_SLOTS));
    slot_ra = slot_in_range ? idx_wide[SLOT_W-1:0] : '0;
  end

  // Reservoir decision and new running values.
  always_comb begin
    fill = (count_r < 32'(KEEP_SLOTS));
    stored = fill || keep_r;
    slot_w = fill ? count_r[SLOT_W-1:0] : slot_prod_r;
    slot_out = (SLOT_W + 4)'(slot_w);
    bal_cur = bal_rv_r ? bal_rd_r : 32'd0;
    dep_cur = dep_rv_r ? dep_rd_r : 32'd0;
    count_new = sat_inc(count_r);
    best_new = (item_r.quality > best_r) ? item_r.quality : best_r;
  end

  // Captured request and arithmetic stages.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.mul_lo) begin
      pp_lo_r <= 48'(acc_a) * 48'(cnt_p1[15:0]);
      slot_prod_r <= slot_prod[32 +: SLOT_W];
    end
    if (cmd.mul_hi) begin
      pp_hi_r <= 49'(acc_a) * 49'(cnt_p1[32:16]);
    end
    if (cmd.hist_rd_add) begin
      keep_r <= (lhs < ACC_LIMIT);
      bal_wa_r <= abin;
      dep_wa_r <= dbin;
    end
  end

  // Running count, best quality and histogram valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      best_r <= '0;
      bal_vld_r <= '0;
      dep_vld_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_new;
      best_r <= best_new;
      bal_vld_r[bal_wa_r] <= 1'b1;
      dep_vld_r[dep_wa_r] <= 1'b1;
    end
  end

  // Histogram memories: one read and one write port each.
  always_ff @(posedge clk) begin
    if (cmd.hist_rd_add || cmd.rd_read) begin
      bal_rd_r <= bal_mem[bal_ra];
      dep_rd_r <= dep_mem[dep_ra];
      bal_rv_r <= bal_vld_r[bal_ra];
      dep_rv_r <= dep_vld_r[dep_ra];
    end
    if (cmd.commit) begin
      bal_mem[bal_wa_r] <= sat_inc(bal_cur);
      dep_mem[dep_wa_r] <= sat_inc(dep_cur);
    end
  end

  // Reservoir slot memory.
  always_ff @(posedge clk) begin
    if (cmd.rd_read) begin
      kid_rd_r <= slot_mem[slot_ra];
      kval_r <= slot_in_range && (32'(item_r.read_index) < count_r);
      bin_ok_r <= (32'(item_r.read_index) < 32'(NUM_BINS));
    end
    if (cmd.commit && stored) begin
      slot_mem[slot_w] <= item_r.sample_id;
    end
  end

  // Result staging and the output register.
  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res_r.accepted <= 1'b0;
      res_r.stored <= 1'b0;
      res_r.slot_written <= '0;
      res_r.sample_count <= count_r;
      res_r.max_quality <= best_r;
      res_r.balance_count <= '0;
      res_r.depth_count <= '0;
      res_r.kept_id <= '0;
      res_r.kept_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_r.accepted <= 1'b1;
      res_r.stored <= stored;
      res_r.slot_written <= stored ? slot_out[3:0] : 4'd0;
      res_r.sample_count <= count_new;
      res_r.max_quality <= best_new;
      res_r.balance_count <= '0;
      res_r.depth_count <= '0;
      res_r.kept_id <= '0;
      res_r.kept_valid <= 1'b0;
    end else if (cmd.res_read) begin
      res_r.accepted <= 1'b0;
      res_r.stored <= 1'b0;
      res_r.slot_written <= '0;
      res_r.sample_count <= count_r;
      res_r.max_quality <= best_r;
      res_r.balance_count <= bin_ok_r ? bal_cur : 32'd0;
      res_r.depth_count <= bin_ok_r ? dep_cur : 32'd0;
      res_r.kept_id <= kval_r ? kid_rd_r : 16'd0;
      res_r.kept_valid <= kval_r;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign stat.is_read = (item_r.func == rshist_pkg::FUNC_READ);
  assign stat.zero_depth = (item_r.depth == 16'd0);
  assign stat.div_done = div_done;
  assign out_data = out_r;

  // A slot write always lands inside the reservoir.
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && stored) |-> (7'(slot_w) < 7'(KEEP_SLOTS)))
    else $error("reservoir slot write out of range");

endmodule

// File: hw/rtl/rshist_ctrl.sv
module rshist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rshist_pkg::dp_stat_t stat,
  output rshist_pkg::dp_cmd_t  cmd
);

  rshist_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rshist_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rshist_pkg::S_DECODE;
        end
      end
      rshist_pkg::S_DECODE: begin
        if (stat.is_read) begin
          state_nxt = rshist_pkg::S_RD;
        end else if (stat.zero_depth) begin
          state_nxt = rshist_pkg::S_RES;
        end else begin
          state_nxt = rshist_pkg::S_DIV;
        end
      end
      rshist_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_nxt = rshist_pkg::S_MUL0;
        end
      end
      rshist_pkg::S_MUL0: state_nxt = rshist_pkg::S_MUL1;
      rshist_pkg::S_MUL1: state_nxt = rshist_pkg::S_CMP;
      rshist_pkg::S_CMP:  state_nxt = rshist_pkg::S_UPD;
      rshist_pkg::S_UPD:  state_nxt = rshist_pkg::S_RES;
      rshist_pkg::S_RD:   state_nxt = rshist_pkg::S_RDW;
      rshist_pkg::S_RDW:  state_nxt = rshist_pkg::S_RES;
      rshist_pkg::S_RES: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rshist_pkg::S_IDLE;
        end
      end
      default: state_nxt = rshist_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      rshist_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      rshist_pkg::S_DECODE: begin
        if (!stat.is_read) begin
          if (stat.zero_depth) begin
            cmd.res_zero = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      rshist_pkg::S_MUL0: cmd.mul_lo = 1'b1;
      rshist_pkg::S_MUL1: cmd.mul_hi = 1'b1;
      rshist_pkg::S_CMP:  cmd.hist_rd_add = 1'b1;
      rshist_pkg::S_UPD:  cmd.commit = 1'b1;
      rshist_pkg::S_RD:   cmd.rd_read = 1'b1;
      rshist_pkg::S_RDW:  cmd.res_read = 1'b1;
      rshist_pkg::S_RES:  cmd.out_load = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rshist_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // The divider finishes only while the controller waits for it.
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == rshist_pkg::S_DIV))
    else $error("divider done outside divide state");

  // Histogram update always follows the keep decision.
  a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rshist_pkg::S_UPD) |-> ($past(state_r) == rshist_pkg::S_CMP))
    else $error("update without keep decision");

endmodule

// File: hw/rtl/reservoir_sampler_with_histograms_top.sv
// Channel  Direction  Ports                          Payload
// in       input      in_valid, in_ready, in_data    rshist_pkg::in_item_t
// out      output     out_valid, out_ready, out_data rshist_pkg::out_item_t
//
// One request at a time. A read passes decode, the read states and the result state; an
// add with zero depth goes from decode to the result state; an add with nonzero depth runs
// the bit-serial bin divider and the split keep-test multiply, low then high half.
// Reset (rst_n, synchronous) clears the count, best quality and histogram valid bits at
// once; there is no clearing pass. A stalled result waits in the output register while
// the next request is already worked on; its result waits in the result state for out_ready.
module reservoir_sampler_with_histograms_top #(
  parameter int KEEP_SLOTS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rshist_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rshist_pkg::out_item_t out_data
);

  rshist_pkg::dp_cmd_t  cmd;
  rshist_pkg::dp_stat_t stat;

  // Sequencer.
  rshist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  rshist_dp #(
    .KEEP_SLOTS (KEEP_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// File: verif/tb_reservoir_sampler_with_histograms_top.sv
`timescale 1ns / 100ps

module tb_reservoir_sampler_with_histograms_top;

  localparam int KEEP_SLOTS = 10;
  localparam int SLOT_IDX_W = $clog2(KEEP_SLOTS);
  localparam int RANDOM_ITEMS = 1800;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    rshist_pkg::in_item_t  req;
    bit                    has_want;
    rshist_pkg::out_item_t want;
  } table_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  rshist_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  rshist_pkg::out_item_t out_data;

  // Shadow copy of the sampler state.
  logic [31:0] shadow_count;
  logic [19:0] shadow_best_q;
  logic [15:0] shadow_slots [KEEP_SLOTS];
  logic [31:0] shadow_bal_hist [rshist_pkg::NUM_BINS];
  logic [31:0] shadow_dep_hist [rshist_pkg::NUM_BINS];

  rshist_pkg::out_item_t pending_results [$];
  table_row_t            directed_rows [$];

  bit rx_hold_req = 1'b0;
  bit quiet_phase = 1'b0;
  int error_cnt = 0;
  int result_cnt = 0;
  int stored_cnt = 0;
  int add_cnt = 0;
  int read_cnt = 0;
  int cycle_cnt = 0;

  reservoir_sampler_with_histograms_top #(
    .KEEP_SLOTS(KEEP_SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  // Mostly no idle cycles, often a few, now and then a long stretch.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Computes the result of one request and advances the shadow state.
  function automatic rshist_pkg::out_item_t predict_sampler(input rshist_pkg::in_item_t req);
    rshist_pkg::out_item_t res;
    logic [31:0] alt;
    logic [31:0] dep;
    logic [31:0] slot_idx;
    logic [31:0] abin;
    logic [31:0] dbin;
    logic [63:0] ra64;
    logic [63:0] rs64;
    logic [63:0] keep_lhs;
    logic [63:0] keep_lim;
    logic [63:0] slot_prod;
    logic        keep;
    res = '0;
    if (req.func == rshist_pkg::FUNC_ADD) begin
      if (req.depth != 16'd0) begin
        res.accepted = 1'b1;
        dep = {16'd0, req.depth};
        alt = (req.alt_count > req.depth) ? dep : {16'd0, req.alt_count};
        if (req.quality > shadow_best_q) shadow_best_q = req.quality;

        // The first slots fill in order; later ids replace a slot by chance.
        keep = 1'b0;
        slot_idx = 32'd0;
        if (shadow_count < 32'(KEEP_SLOTS)) begin
          slot_idx = shadow_count;
          keep = 1'b1;
        end else begin
          ra64 = {33'd0, req.draw_accept};
          rs64 = {33'd0, req.draw_slot};
          keep_lhs = (64'd2 * ra64 + 64'd1) * ({32'd0, shadow_count} + 64'd1);
          keep_lim = 64'(KEEP_SLOTS) << 32;
          if (keep_lhs < keep_lim) begin
            slot_prod = (64'd2 * rs64 + 64'd1) * 64'(KEEP_SLOTS);
            slot_idx = slot_prod[63:32];
            keep = 1'b1;
          end
        end
        if (keep && slot_idx < 32'(KEEP_SLOTS))
          shadow_slots[slot_idx[SLOT_IDX_W-1:0]] = req.sample_id;
        else keep = 1'b0;
        res.stored = keep;
        res.slot_written = keep ? slot_idx[3:0] : 4'd0;

        // Histogram bins.
        abin = (alt == 32'd0) ? 32'd0 : (32'd20 * alt - 32'd1) / dep;
        if (abin > 32'd19) abin = 32'd19;
        dbin = dep / 32'd5;
        if (dbin > 32'd19) dbin = 32'd19;
        shadow_bal_hist[abin[rshist_pkg::BIN_W-1:0]] =
          sat_inc(shadow_bal_hist[abin[rshist_pkg::BIN_W-1:0]]);
        shadow_dep_hist[dbin[rshist_pkg::BIN_W-1:0]] =
          sat_inc(shadow_dep_hist[dbin[rshist_pkg::BIN_W-1:0]]);
        shadow_count = sat_inc(shadow_count);
      end
    end else begin
      if (32'(req.read_index) < rshist_pkg::NUM_BINS) begin
        res.balance_count = shadow_bal_hist[req.read_index];
        res.depth_count = shadow_dep_hist[req.read_index];
      end
      if (32'(req.read_index) < 32'(KEEP_SLOTS) && 32'(req.read_index) < shadow_count) begin
        res.kept_valid = 1'b1;
        res.kept_id = shadow_slots[req.read_index[SLOT_IDX_W-1:0]];
      end
    end
    res.sample_count = shadow_count;
    res.max_quality = shadow_best_q;
    return res;
  endfunction

  function automatic rshist_pkg::in_item_t mk_add(input logic [15:0] id,
                                                  input logic [15:0] alt,
                                                  input logic [15:0] dep,
                                                  input logic [19:0] qual,
                                                  input logic [30:0] ra,
                                                  input logic [30:0] rs);
    rshist_pkg::in_item_t req;
    req = '0;
    req.func = rshist_pkg::FUNC_ADD;
    req.sample_id = id;
    req.alt_count = alt;
    req.depth = dep;
    req.quality = qual;
    req.draw_accept = ra;
    req.draw_slot = rs;
    return req;
  endfunction

  function automatic rshist_pkg::in_item_t mk_read(input logic [4:0] idx);
    rshist_pkg::in_item_t req;
    req = '0;
    req.func = rshist_pkg::FUNC_READ;
    req.read_index = idx;
    return req;
  endfunction

  function automatic rshist_pkg::out_item_t mk_result(input logic acc, input logic st,
                                                      input logic [3:0] slot,
                                                      input logic [31:0] cnt,
                                                      input logic [19:0] maxq,
                                                      input logic [31:0] bal,
                                                      input logic [31:0] dep,
                                                      input logic [15:0] kid,
                                                      input logic kval);
    rshist_pkg::out_item_t res;
    res.accepted = acc;
    res.stored = st;
    res.slot_written = slot;
    res.sample_count = cnt;
    res.max_quality = maxq;
    res.balance_count = bal;
    res.depth_count = dep;
    res.kept_id = kid;
    res.kept_valid = kval;
    return res;
  endfunction

  task automatic add_row(input rshist_pkg::in_item_t req, input bit has_want,
                         input rshist_pkg::out_item_t want);
    table_row_t row;
    row.req = req;
    row.has_want = has_want;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Random request: mostly adds with small depths and biased draws so that
  // late samples still get kept now and then.
  function automatic rshist_pkg::in_item_t random_request();
    rshist_pkg::in_item_t req;
    int                   roll;
    req.func = ($urandom_range(0, 99) < 65) ? rshist_pkg::FUNC_ADD : rshist_pkg::FUNC_READ;
    req.sample_id = 16'($urandom);
    req.quality = 20'($urandom);
    req.draw_slot = 31'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 10) req.depth = 16'd0;
    else if (roll < 70) req.depth = 16'($urandom_range(1, 200));
    else req.depth = 16'($urandom);
    if ($urandom_range(0, 99) < 70) req.alt_count = 16'($urandom_range(0, req.depth));
    else req.alt_count = 16'($urandom);
    if ($urandom_range(0, 1) == 0) req.draw_accept = 31'($urandom);
    else req.draw_accept = 31'($urandom_range(0, 32'h7FFF_FFFF >> $urandom_range(0, 12)));
    if ($urandom_range(0, 99) < 70)
      req.read_index = 5'($urandom_range(0, rshist_pkg::NUM_BINS - 1));
    else req.read_index = 5'($urandom_range(0, 31));
    return req;
  endfunction

  // Offers one request after a random gap and records its expected result
  // once the handshake completes.
  task automatic offer_request(input rshist_pkg::in_item_t req, input bit has_want,
                               input rshist_pkg::out_item_t want);
    int                    gap;
    rshist_pkg::out_item_t pred;
    gap = quiet_phase ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pred = predict_sampler(req);
    pending_results.insert(pending_results.size(), has_want ? want : pred);
    if (req.func == rshist_pkg::FUNC_ADD) add_cnt++;
    else read_cnt++;
  endtask

  // Result side backpressure, including one long hold-off on request.
  initial begin : result_backpressure
    int stall;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        stall = quiet_phase ? 0 : idle_len();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_cnt++;
      if (error_cnt <= 10)
        $display("Result %0d, %s: expected %h, got %h", result_cnt, fname, want, got);
    end
  endtask

  // Compare each handed-off result against the oldest expectation.
  always @(posedge clk) begin : result_check
    rshist_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10) $display("Unexpected result %h with nothing pending.", out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
        check_field("stored", 32'(want.stored), 32'(out_data.stored));
        check_field("slot_written", 32'(want.slot_written), 32'(out_data.slot_written));
        check_field("sample_count", want.sample_count, out_data.sample_count);
        check_field("max_quality", 32'(want.max_quality), 32'(out_data.max_quality));
        check_field("balance_count", want.balance_count, out_data.balance_count);
        check_field("depth_count", want.depth_count, out_data.depth_count);
        check_field("kept_id", 32'(want.kept_id), 32'(out_data.kept_id));
        check_field("kept_valid", 32'(want.kept_valid), 32'(out_data.kept_valid));
      end
      if (out_data.stored === 1'b1) stored_cnt++;
      result_cnt++;
    end
  end

  initial begin : stimulus
    rshist_pkg::in_item_t req;
    int                   i;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    shadow_count = '0;
    shadow_best_q = '0;
    for (i = 0; i < KEEP_SLOTS; i++) shadow_slots[i] = '0;
    for (i = 0; i < rshist_pkg::NUM_BINS; i++) begin
      shadow_bal_hist[i] = '0;
      shadow_dep_hist[i] = '0;
    end

    // Directed table: reads of an empty block, zero depth, the first fills,
    // clamping, bin edges, and the keep test at both ends of the draws.
    add_row(mk_read(5'd0), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_read(5'd19), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_read(5'd31), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_add(16'hFFFF, 16'd5, 16'd0, 20'hFFFFF, '1, '1), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_add(16'd1, 16'd0, 16'd1, 20'd0, '1, '1), 1'b1,
            mk_result(1'b1, 1'b1, 4'd0, 32'd1, 20'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_add(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, '0, '0), 1'b1,
            mk_result(1'b1, 1'b1, 4'd1, 32'd2, 20'hFFFFF, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_read(5'd0), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd2, 20'hFFFFF, 32'd1, 32'd1, 16'd1, 1'b1));
    add_row(mk_read(5'd19), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd2, 20'hFFFFF, 32'd1, 32'd1, 16'd0, 1'b0));
    add_row(mk_read(5'd1), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd2, 20'hFFFFF, 32'd0, 32'd0, 16'hFFFF, 1'b1));
    add_row(mk_read(5'd2), 1'b1,
            mk_result(1'b0, 1'b0, 4'd0, 32'd2, 20'hFFFFF, 32'd0, 32'd0, 16'd0, 1'b0));
    add_row(mk_add(16'h0102, 16'd100, 16'd7, 20'd10, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0203, 16'd47, 16'd94, 20'h12345, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0304, 16'd1, 16'd95, 20'd3, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0405, 16'd4, 16'd4, 20'd4, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0506, 16'd3, 16'd5, 20'd5, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0607, 16'd1, 16'd20, 20'd6, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0708, 16'd19, 16'd20, 20'd7, '0, '0), 1'b0, '0);
    add_row(mk_add(16'h0809, 16'd2, 16'd3, 20'd8, '0, '0), 1'b0, '0);
    add_row(mk_add(16'hA0A0, 16'd9, 16'd50, 20'd9, '0, '0), 1'b0, '0);
    add_row(mk_add(16'hB0B0, 16'd9, 16'd50, 20'd9, '0, '1), 1'b0, '0);
    add_row(mk_add(16'hC0C0, 16'd9, 16'd50, 20'd9, '1, '0), 1'b0, '0);
    add_row(mk_add(16'hD0D0, 16'd9, 16'd0, 20'hFFFFF, '0, '0), 1'b0, '0);
    add_row(mk_read(5'd9), 1'b0, '0);
    add_row(mk_read(5'd20), 1'b0, '0);
    add_row(mk_read(5'd10), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      offer_request(directed_rows[k].req, directed_rows[k].has_want, directed_rows[k].want);

    // Random requests with one long output hold-off, one full drain pause and
    // a stretch without idle cycles on either side.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) rx_hold_req = 1'b1;
      if (i == 600) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      quiet_phase = (i >= 900 && i < 1100);
      req = random_request();
      offer_request(req, 1'b0, '0);
    end

    // Let every outstanding result drain, then watch for strays.
    in_valid <= 1'b0;
    quiet_phase = 1'b1;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d add and %0d read requests; %0d results checked, %0d ids kept.",
             add_cnt, read_cnt, result_cnt, stored_cnt);
    $display("Included a long output hold-off, a full drain pause and a back-to-back run.");
    if (error_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors found.", error_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
